// ===== rtl/dist_pkg.sv =====
// Package for the device identity status table.
// Holds table sizes, operation and status codes, shared structs and helper functions.
// No dependencies.
package dist_pkg;

    localparam int TABLE_ENTRIES  = 16;
    localparam int MAKER_TEXT_MAX = 32;
    localparam int MODEL_TEXT_MAX = 32;
    localparam int MAKER_LEN_W    = $clog2(MAKER_TEXT_MAX);
    localparam int MODEL_LEN_W    = $clog2(MODEL_TEXT_MAX);
    localparam logic [7:0] MAKER_LIM = 8'(MAKER_TEXT_MAX - 1);
    localparam logic [7:0] MODEL_LIM = 8'(MODEL_TEXT_MAX - 1);

    localparam logic [15:0] FREE_ADDR = 16'hFFFF;

    localparam logic [2:0] OP_MARK        = 3'd0;
    localparam logic [2:0] OP_STORE_MAKER = 3'd1;
    localparam logic [2:0] OP_STORE_MODEL = 3'd2;
    localparam logic [2:0] OP_FAIL        = 3'd3;
    localparam logic [2:0] OP_FIND        = 3'd4;
    localparam logic [2:0] OP_REMOVE      = 3'd5;
    localparam logic [2:0] OP_CLEAR       = 3'd6;

    localparam logic [1:0] ST_UNKNOWN  = 2'd0;
    localparam logic [1:0] ST_PENDING  = 2'd1;
    localparam logic [1:0] ST_RESOLVED = 2'd2;
    localparam logic [1:0] ST_FAILED   = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  len;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic apply;
    } t_ctl;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] maker;
        logic [4:0] model;
    } t_result;

    function automatic logic [7:0] clip_len(input logic [7:0] len, input logic [7:0] lim);
        return (len < lim) ? len : lim;
    endfunction

    function automatic logic [4:0] fit5(input logic [7:0] v);
        return v[4:0];
    endfunction

endpackage

// ===== rtl/dist_in_if.sv =====
// Input channel of the device identity status table: valid/ready plus one operation.
// No dependencies.
interface dist_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [15:0] device_address;
    logic [7:0]  text_length;

    modport source (output valid, output operation, output device_address,
                    output text_length, input ready);
    modport sink   (input valid, input operation, input device_address,
                    input text_length, output ready);
endinterface

// ===== rtl/dist_out_if.sv =====
// Result channel of the device identity status table: valid/ready plus one result.
// No dependencies.
interface dist_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [1:0] entry_status;
    logic [4:0] maker_length;
    logic [4:0] model_length_out;

    modport source (output valid, output accepted, output entry_status,
                    output maker_length, output model_length_out, input ready);
    modport sink   (input valid, input accepted, input entry_status,
                    input maker_length, input model_length_out, output ready);
endinterface

// ===== rtl/dist_cell.sv =====
// One table slot: address, status and both text lengths, with its match and update logic.
// Free-slot priority and the result pass from cell to cell. Depends on dist_pkg.
module dist_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dist_pkg::t_ctl    i_ctl,
    input  dist_pkg::t_cmd    i_cmd,
    input  logic              i_free_in,
    output logic              o_free_out,
    input  logic              i_any_hit,
    output logic              o_hit,
    output logic              o_claim,
    input  dist_pkg::t_result i_res,
    output dist_pkg::t_result o_res
);
    import dist_pkg::*;

    logic [15:0]            r_addr;
    logic [1:0]             r_status;
    logic [MAKER_LEN_W-1:0] r_maker;
    logic [MODEL_LEN_W-1:0] r_model;
    logic                   r_hit;
    logic                   r_claim;

    logic [15:0]            n_addr;
    logic [1:0]             n_status;
    logic [MAKER_LEN_W-1:0] n_maker;
    logic [MODEL_LEN_W-1:0] n_model;
    logic                   slot_free;
    logic                   key_ok;
    logic                   sel;
    t_result                mine;

    assign slot_free  = (r_addr == FREE_ADDR);
    assign key_ok     = (i_cmd.addr != FREE_ADDR);
    assign o_free_out = i_free_in | slot_free;
    assign o_hit      = r_hit;
    assign o_claim    = r_claim;

    assign sel = (r_hit && i_cmd.op <= OP_REMOVE)
               | (r_claim && !i_any_hit && i_cmd.op == OP_MARK);

    always_comb begin
        n_addr   = r_addr;
        n_status = r_status;
        n_maker  = r_maker;
        n_model  = r_model;
        case (i_cmd.op)
            OP_MARK: begin
                n_addr = i_cmd.addr;
                if (r_status == ST_UNKNOWN) begin
                    n_status = ST_PENDING;
                end
            end
            OP_STORE_MAKER: begin
                n_maker = MAKER_LEN_W'(clip_len(i_cmd.len, MAKER_LIM));
                if (r_status == ST_PENDING && n_maker != '0 && r_model != '0) begin
                    n_status = ST_RESOLVED;
                end
            end
            OP_STORE_MODEL: begin
                n_model = MODEL_LEN_W'(clip_len(i_cmd.len, MODEL_LIM));
                if (r_status == ST_PENDING && r_maker != '0 && n_model != '0) begin
                    n_status = ST_RESOLVED;
                end
            end
            OP_FAIL: begin
                n_status = ST_FAILED;
            end
            OP_REMOVE: begin
                n_addr   = FREE_ADDR;
                n_status = ST_UNKNOWN;
                n_maker  = '0;
                n_model  = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mine.status = n_status;
        mine.maker  = fit5(8'(n_maker));
        mine.model  = fit5(8'(n_model));
        o_res = sel ? (i_res | mine) : i_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= FREE_ADDR;
            r_status <= ST_UNKNOWN;
            r_maker  <= '0;
            r_model  <= '0;
            r_hit    <= 1'b0;
            r_claim  <= 1'b0;
        end else begin
            if (i_ctl.match) begin
                r_hit   <= key_ok && (r_addr == i_cmd.addr);
                r_claim <= key_ok && slot_free && !i_free_in;
            end
            if (i_ctl.apply && i_cmd.op == OP_CLEAR) begin
                r_addr   <= FREE_ADDR;
                r_status <= ST_UNKNOWN;
                r_maker  <= '0;
                r_model  <= '0;
            end else if (i_ctl.apply && sel) begin
                r_addr   <= n_addr;
                r_status <= n_status;
                r_maker  <= n_maker;
                r_model  <= n_model;
            end
        end
    end

endmodule

// ===== rtl/device_identity_status_table.sv =====
// Device identity status table: a row of slot cells keyed by 16-bit device address,
// taking one operation per transfer and returning one result transfer per operation.
// An operation passes through accept, match across the cell row (with first-free priority
// rippling neighbor to neighbor), then update and result capture. The next operation is
// accepted once the update is done, while the result may still wait in the output register.
// Address 0xFFFF is refused. Depends on dist_pkg, dist_in_if, dist_out_if, dist_cell.
module device_identity_status_table (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dist_in_if.sink    i_in,
    dist_out_if.source o_out
);
    import dist_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_cmd       r_cmd;
    t_ctl       ctl;

    logic       r_out_valid;
    logic       r_out_acc;
    t_result    r_out_res;

    logic [TABLE_ENTRIES-1:0] hits;
    logic [TABLE_ENTRIES-1:0] claims;
    logic                     free_chain [0:TABLE_ENTRIES];
    t_result                  res_chain  [0:TABLE_ENTRIES];
    logic                     any_hit;
    logic                     any_claim;
    logic                     fire;
    logic                     acc;

    assign free_chain[0] = 1'b0;
    assign res_chain[0]  = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        dist_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_cmd      (r_cmd),
            .i_free_in  (free_chain[g]),
            .o_free_out (free_chain[g+1]),
            .i_any_hit  (any_hit),
            .o_hit      (hits[g]),
            .o_claim    (claims[g]),
            .i_res      (res_chain[g]),
            .o_res      (res_chain[g+1])
        );
    end

    assign any_hit   = |hits;
    assign any_claim = |claims;
    assign fire      = (r_state == S_APPLY) && (!r_out_valid || o_out.ready);
    assign acc       = (any_hit && r_cmd.op <= OP_REMOVE)
                     | (any_claim && r_cmd.op == OP_MARK)
                     | (r_cmd.op == OP_CLEAR);

    assign ctl.match = (r_state == S_MATCH);
    assign ctl.apply = fire;

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_MATCH;
            S_MATCH: n_state = S_APPLY;
            S_APPLY: if (fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && r_state == S_IDLE) begin
            r_cmd.op   <= i_in.operation;
            r_cmd.addr <= i_in.device_address;
            r_cmd.len  <= i_in.text_length;
        end
        if (fire) begin
            r_out_acc <= acc;
            r_out_res <= res_chain[TABLE_ENTRIES];
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.accepted         = r_out_acc;
    assign o_out.entry_status     = r_out_res.status;
    assign o_out.maker_length     = r_out_res.maker;
    assign o_out.model_length_out = r_out_res.model;

endmodule

// ===== dv/device_identity_status_table_checker.sv =====
`timescale 1ns / 100ps
// Checker for the device identity status table: watches the operation and result channels,
// predicts each result from its own copy of the table and compares it field by field.
// Depends on dist_pkg, dist_in_if and dist_out_if.
module device_identity_status_table_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dist_in_if   i_op_ch,
    dist_out_if  i_reply_ch,
    output int   o_fail_count,
    output int   o_results_due
);
    import dist_pkg::*;

    typedef struct packed {
        logic       accepted;
        logic [1:0] status;
        logic [4:0] maker;
        logic [4:0] model;
    } t_table_reply;

    logic [15:0] slot_addr      [TABLE_ENTRIES];
    logic [1:0]  slot_state     [TABLE_ENTRIES];
    logic [7:0]  slot_maker_len [TABLE_ENTRIES];
    logic [7:0]  slot_model_len [TABLE_ENTRIES];

    t_table_reply replies_due[$];
    int fail_total = 0;
    int due_count  = 0;

    assign o_fail_count  = fail_total;
    assign o_results_due = due_count;

    function automatic void wipe_slot(input int idx);
        slot_addr[idx]      = FREE_ADDR;
        slot_state[idx]     = ST_UNKNOWN;
        slot_maker_len[idx] = '0;
        slot_model_len[idx] = '0;
    endfunction

    function automatic void wipe_table();
        for (int idx = 0; idx < TABLE_ENTRIES; idx++) wipe_slot(idx);
    endfunction

    function automatic void settle_status(input int idx);
        if (slot_state[idx] == ST_PENDING && slot_maker_len[idx] != 0 &&
            slot_model_len[idx] != 0) begin
            slot_state[idx] = ST_RESOLVED;
        end
    endfunction

    // Applies one operation to the table copy and returns the result it should produce.
    function automatic t_table_reply apply_table_op(input logic [2:0] op,
                                                    input logic [15:0] addr,
                                                    input logic [7:0] len);
        t_table_reply reply;
        int hit;
        reply = '0;
        hit   = -1;
        if (addr != FREE_ADDR) begin
            for (int idx = 0; idx < TABLE_ENTRIES; idx++)
                if (hit < 0 && slot_addr[idx] == addr) hit = idx;
        end
        case (op)
            OP_MARK: begin
                if (addr != FREE_ADDR && hit < 0) begin
                    for (int idx = 0; idx < TABLE_ENTRIES; idx++) begin
                        if (hit < 0 && slot_addr[idx] == FREE_ADDR) begin
                            hit = idx;
                            slot_addr[idx] = addr;
                        end
                    end
                end
                if (hit >= 0 && slot_state[hit] == ST_UNKNOWN) slot_state[hit] = ST_PENDING;
            end
            OP_STORE_MAKER: begin
                if (hit >= 0) begin
                    slot_maker_len[hit] = (len < MAKER_LIM) ? len : MAKER_LIM;
                    settle_status(hit);
                end
            end
            OP_STORE_MODEL: begin
                if (hit >= 0) begin
                    slot_model_len[hit] = (len < MODEL_LIM) ? len : MODEL_LIM;
                    settle_status(hit);
                end
            end
            OP_FAIL: begin
                if (hit >= 0) slot_state[hit] = ST_FAILED;
            end
            OP_FIND: begin
            end
            OP_REMOVE: begin
                if (hit >= 0) wipe_slot(hit);
            end
            OP_CLEAR: begin
                wipe_table();
                hit = -1;
                reply.accepted = 1'b1;
            end
            default: hit = -1;
        endcase
        if (hit >= 0) begin
            reply.accepted = 1'b1;
            reply.status   = slot_state[hit];
            reply.maker    = slot_maker_len[hit][4:0];
            reply.model    = slot_model_len[hit][4:0];
        end
        return reply;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        fail_total++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_table_reply due;
        t_table_reply seen;
        if (!i_rst_n) begin
            wipe_table();
            replies_due.delete();
        end else begin
            if (i_reply_ch.valid && i_reply_ch.ready) begin
                seen.accepted = i_reply_ch.accepted;
                seen.status   = i_reply_ch.entry_status;
                seen.maker    = i_reply_ch.maker_length;
                seen.model    = i_reply_ch.model_length_out;
                if (replies_due.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result transfer, expected none, actual %h",
                             $time, seen);
                end else begin
                    due = replies_due.pop_front();
                    if (seen.accepted !== due.accepted)
                        note_mismatch("accepted", due.accepted, seen.accepted);
                    if (seen.status !== due.status)
                        note_mismatch("entry_status", due.status, seen.status);
                    if (seen.maker !== due.maker)
                        note_mismatch("maker_length", due.maker, seen.maker);
                    if (seen.model !== due.model)
                        note_mismatch("model_length_out", due.model, seen.model);
                end
            end
            if (i_op_ch.valid && i_op_ch.ready)
                replies_due.push_back(apply_table_op(i_op_ch.operation,
                                                     i_op_ch.device_address,
                                                     i_op_ch.text_length));
        end
        due_count = replies_due.size();
    end

endmodule

// ===== dv/device_identity_status_table_test.sv =====
`timescale 1ns / 100ps
// Top of the device identity status table testbench: clock, reset, operation stimulus,
// result-side stalls and the verdict. Depends on dist_pkg, both channel interfaces,
// the table RTL and device_identity_status_table_checker.
module device_identity_status_table_test;
    import dist_pkg::*;

    localparam logic [2:0] OP_UNDEFINED = 3'd7;
    localparam int RANDOM_OPS  = 1400;
    localparam int POOL_SIZE   = 24;
    localparam int HOLD_AFTER  = 500;
    localparam int HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   results_due;
    int   ops_sent = 0;
    bit   idle_on  = 1'b1;

    logic [15:0] addr_pool [POOL_SIZE];

    dist_in_if  u_in_ch ();
    dist_out_if u_out_ch ();

    device_identity_status_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_ch),
        .o_out   (u_out_ch)
    );

    device_identity_status_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_ch       (u_in_ch),
        .i_reply_ch    (u_out_ch),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("device_identity_status_table_test: FAIL");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off so the table backs up.
    initial begin
        bit hold_done;
        int hold_left;
        hold_done = 1'b0;
        hold_left = 0;
        u_out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && ops_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                u_out_ch.ready = 1'b0;
            end else begin
                u_out_ch.ready = !(idle_on && $urandom_range(99) < 17);
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_op(input logic [2:0] op, input logic [15:0] addr,
                           input logic [7:0] len);
        while (idle_on && $urandom_range(99) < 17) @(negedge i_clk);
        u_in_ch.valid          = 1'b1;
        u_in_ch.operation      = op;
        u_in_ch.device_address = addr;
        u_in_ch.text_length    = len;
        @(posedge i_clk);
        while (!u_in_ch.ready) @(posedge i_clk);
        ops_sent++;
        @(negedge i_clk);
        u_in_ch.valid = 1'b0;
    endtask

    initial begin
        int          pick;
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  len;

        u_in_ch.valid          = 1'b0;
        u_in_ch.operation      = OP_FIND;
        u_in_ch.device_address = '0;
        u_in_ch.text_length    = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_op(OP_FIND,        16'h0000, 8'd0);
        send_op(OP_UNDEFINED,   16'h1234, 8'd77);
        send_op(OP_MARK,        FREE_ADDR, 8'd0);
        send_op(OP_STORE_MAKER, FREE_ADDR, 8'd10);
        send_op(OP_MARK,        16'h0000, 8'd0);
        send_op(OP_STORE_MAKER, 16'h0000, 8'd255);
        send_op(OP_STORE_MODEL, 16'h0000, 8'd0);
        send_op(OP_STORE_MODEL, 16'h0000, 8'd1);
        send_op(OP_FIND,        16'h0000, 8'd0);
        send_op(OP_FAIL,        16'h0000, 8'd0);
        send_op(OP_MARK,        16'h0000, 8'd0);
        send_op(OP_REMOVE,      16'h0000, 8'd0);
        send_op(OP_REMOVE,      16'h0000, 8'd0);
        send_op(OP_MARK,        16'hFFFE, 8'd0);
        send_op(OP_STORE_MODEL, 16'hFFFE, 8'd31);
        send_op(OP_STORE_MAKER, 16'hFFFE, 8'd30);
        send_op(OP_FAIL,        16'h5555, 8'd0);
        send_op(OP_FIND,        16'hFFFE, 8'd0);
        send_op(OP_CLEAR,       FREE_ADDR, 8'd255);
        send_op(OP_FIND,        16'hFFFE, 8'd0);
        send_op(OP_STORE_MAKER, 16'hFFFE, 8'd5);

        for (int idx = 0; idx < POOL_SIZE; idx++)
            addr_pool[idx] = 16'($urandom_range(16'hFFFE, 0));

        for (int item = 0; item < RANDOM_OPS; item++) begin
            idle_on = !(item >= 700 && item < 900);
            if ($urandom_range(99) < 5)
                addr_pool[$urandom_range(POOL_SIZE - 1)] = 16'($urandom_range(16'hFFFE, 0));

            pick = $urandom_range(99);
            if (pick < 25)      op = OP_MARK;
            else if (pick < 43) op = OP_STORE_MAKER;
            else if (pick < 61) op = OP_STORE_MODEL;
            else if (pick < 67) op = OP_FAIL;
            else if (pick < 82) op = OP_FIND;
            else if (pick < 94) op = OP_REMOVE;
            else if (pick < 96) op = OP_UNDEFINED;
            else if (pick < 97) op = OP_CLEAR;
            else                op = OP_FIND;

            pick = $urandom_range(99);
            if (pick < 90)      addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
            else if (pick < 95) addr = 16'($urandom);
            else                addr = FREE_ADDR;

            case ($urandom_range(3))
                0:       len = 8'd0;
                1:       len = 8'($urandom_range(30, 1));
                2:       len = 8'($urandom_range(255, 31));
                default: len = 8'($urandom);
            endcase

            send_op(op, addr, len);
        end

        wait (results_due == 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("device_identity_status_table_test: PASS");
        else
            $display("device_identity_status_table_test: FAIL");
        $finish;
    end

endmodule
